### rtl/dppb_pkg.sv
// types and constants shared by the ping-pong buffer controller
// no dependencies
`default_nettype none

package dppb_pkg;

  localparam int unsigned LEN_W    = 17;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PADDR_W  = 4;
  localparam logic [LEN_W-1:0] BUF_SIZE_RESET = 17'd1024;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_WRITE     = 3'd1,
    OP_DMA_EVENT = 3'd2,
    OP_STOP      = 3'd3,
    OP_STATUS    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_READY    = 2'd0,
    MODE_BUSY     = 2'd1,
    MODE_COMPLETE = 2'd2,
    MODE_ERROR    = 2'd3
  } mode_t;

  localparam logic [1:0] REG_BASE_A   = 2'd0;
  localparam logic [1:0] REG_BASE_B   = 2'd1;
  localparam logic [1:0] REG_BUF_SIZE = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic [WORD_W-1:0] xfer_total;
    logic [LEN_W-1:0]  request_len;
    logic              engine_busy;
    logic              tc_flag;
    logic              err_flag;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [LEN_W-1:0]  copy_bytes;
    logic [WORD_W-1:0] fill_addr;
    logic              start_xfer;
    logic [WORD_W-1:0] xfer_addr;
    logic [LEN_W-1:0]  xfer_len;
    logic              stop_xfer;
    logic              complete_event;
    logic              error_event;
    logic [1:0]        run_state;
    logic [WORD_W-1:0] remaining;
    logic [LEN_W-1:0]  space_left;
  } out_t;

  typedef struct packed {
    logic [WORD_W-1:0] base_a;
    logic [WORD_W-1:0] base_b;
    logic [LEN_W-1:0]  size_bytes;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/dppb_cfg.sv
// apb register file: buffer bases and buffer size
// depends on dppb_pkg
`default_nettype none

module dppb_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dppb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dppb_pkg::WORD_W-1:0]   pwdata,
  output logic      [dppb_pkg::WORD_W-1:0]   prdata,
  output logic                               pready,
  output dppb_pkg::cfg_t                     cfg
);
  import dppb_pkg::*;

  logic [WORD_W-1:0] base_a_r;
  logic [WORD_W-1:0] base_b_r;
  logic [LEN_W-1:0]  size_bytes_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_a_r     <= '0;
      base_b_r     <= '0;
      size_bytes_r <= BUF_SIZE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_A:   base_a_r     <= pwdata;
        REG_BASE_B:   base_b_r     <= pwdata;
        REG_BUF_SIZE: size_bytes_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_A:   prdata = base_a_r;
      REG_BASE_B:   prdata = base_b_r;
      REG_BUF_SIZE: prdata = {{(WORD_W-LEN_W){1'b0}}, size_bytes_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.base_a     = base_a_r;
  assign cfg.base_b     = base_b_r;
  assign cfg.size_bytes = size_bytes_r;

endmodule

`default_nettype wire

### rtl/dma_ping_pong_buffer_controller.sv
// ping-pong dma transmit controller: top level with beat pipeline and control state
// depends on dppb_pkg and dppb_cfg
//
// usage:
//   in_valid/in_ready/in_data carry one command beat: start, write, dma event,
//   stop or status. every accepted beat yields exactly one result beat on
//   out_valid/out_ready/out_data, in order.
//   the apb port (psel..pready) holds buffer base a, base b and buffer size;
//   write it only while no beat is in flight.
//   a beat accepted into the input register is processed and placed in the
//   result register when that register is free or out_ready is high;
//   out_valid rises once the result register holds it.
//   throughput: one beat per cycle while out_ready is high; the input register
//   and the result register decouple the sides, and the control state updates
//   in the same cycle that builds the result.
//   stall: while out_ready is low the result register holds, the input
//   register fills, and in_ready drops once both are occupied.
//   reset (rst_n low, synchronous): run state ready, counters and marks
//   cleared, registers back to their reset values, both stages empty.
`default_nettype none

module dma_ping_pong_buffer_controller #(
  parameter int unsigned MAX_BUFFER_BYTES = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire dppb_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dppb_pkg::out_t                     out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dppb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dppb_pkg::WORD_W-1:0]   pwdata,
  output logic      [dppb_pkg::WORD_W-1:0]   prdata,
  output logic                               pready
);
  import dppb_pkg::*;

  localparam logic [WORD_W-1:0] MaxBytes = WORD_W'(MAX_BUFFER_BYTES);
  localparam logic [LEN_W-1:0]  MaxLen   = LEN_W'(MAX_BUFFER_BYTES);

  cfg_t cfg;

  dppb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // beat pipeline
  in_t  in_r;
  logic in_v_r;
  out_t out_r;
  logic out_v_r;
  out_t res_nxt;
  logic adv;

  assign adv       = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (adv) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    if (adv) out_r <= res_nxt;
  end

  // control state
  mode_t             mode_r, mode_nxt;
  logic              fill_sel_r, fill_sel_nxt;
  logic [LEN_W-1:0]  fill_count_r, fill_count_nxt;
  logic [WORD_W-1:0] bytes_left_r, bytes_left_nxt;
  logic              ready_a_r, ready_a_nxt;
  logic              ready_b_r, ready_b_nxt;
  logic              tx_active_r, tx_active_nxt;
  logic              tx_sel_r, tx_sel_nxt;
  logic [LEN_W-1:0]  tx_len_r, tx_len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_READY;
      fill_sel_r   <= 1'b0;
      fill_count_r <= '0;
      bytes_left_r <= '0;
      ready_a_r    <= 1'b0;
      ready_b_r    <= 1'b0;
      tx_active_r  <= 1'b0;
      tx_sel_r     <= 1'b0;
      tx_len_r     <= '0;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      fill_sel_r   <= fill_sel_nxt;
      fill_count_r <= fill_count_nxt;
      bytes_left_r <= bytes_left_nxt;
      ready_a_r    <= ready_a_nxt;
      ready_b_r    <= ready_b_nxt;
      tx_active_r  <= tx_active_nxt;
      tx_sel_r     <= tx_sel_nxt;
      tx_len_r     <= tx_len_nxt;
    end
  end

  // effective buffer size, clamped to 1..MAX_BUFFER_BYTES
  logic [LEN_W-1:0] eff_size;

  always_comb begin
    if (cfg.size_bytes == '0) begin
      eff_size = LEN_W'(1);
    end else if ({{(WORD_W-LEN_W){1'b0}}, cfg.size_bytes} > MaxBytes) begin
      eff_size = MaxLen;
    end else begin
      eff_size = cfg.size_bytes;
    end
  end

  function automatic logic [LEN_W-1:0] free_of(
    input mode_t            md,
    input logic             txa,
    input logic             txs,
    input logic             fsel,
    input logic [LEN_W-1:0] fc,
    input logic [LEN_W-1:0] sz
  );
    logic [LEN_W-1:0] r;
    r = '0;
    if (md == MODE_BUSY && !(txa && txs == fsel) && fc < sz) r = sz - fc;
    return r;
  endfunction

  logic [LEN_W-1:0]  free_cur;
  logic [WORD_W-1:0] fill_base;
  logic [WORD_W-1:0] eff_size_w;
  logic [WORD_W-1:0] tx_len_w;
  logic [WORD_W-1:0] done_bytes;
  logic [WORD_W-1:0] left_after;
  logic [LEN_W-1:0]  copy_c;
  logic [LEN_W-1:0]  fc_sum;
  logic              ra_now;

  assign free_cur   = free_of(mode_r, tx_active_r, tx_sel_r, fill_sel_r, fill_count_r,
                              eff_size);
  assign fill_base  = fill_sel_r ? cfg.base_b : cfg.base_a;
  assign eff_size_w = {{(WORD_W-LEN_W){1'b0}}, eff_size};
  assign tx_len_w   = {{(WORD_W-LEN_W){1'b0}}, tx_len_r};
  assign done_bytes = (tx_len_w > bytes_left_r) ? bytes_left_r : tx_len_w;
  assign left_after = bytes_left_r - done_bytes;
  assign copy_c     = (in_r.request_len > free_cur) ? free_cur : in_r.request_len;
  assign fc_sum     = fill_count_r + copy_c;
  assign ra_now     = ready_a_r || !fill_sel_r;

  logic acc_f, start_f, stop_f, compl_f, err_f;

  // next state
  always_comb begin
    mode_nxt       = mode_r;
    fill_sel_nxt   = fill_sel_r;
    fill_count_nxt = fill_count_r;
    bytes_left_nxt = bytes_left_r;
    ready_a_nxt    = ready_a_r;
    ready_b_nxt    = ready_b_r;
    tx_active_nxt  = tx_active_r;
    tx_sel_nxt     = tx_sel_r;
    tx_len_nxt     = tx_len_r;
    acc_f          = 1'b0;
    start_f        = 1'b0;
    stop_f         = 1'b0;
    compl_f        = 1'b0;
    err_f          = 1'b0;
    unique case (op_t'(in_r.op))
      OP_START: begin
        if (mode_r != MODE_BUSY) begin
          bytes_left_nxt = in_r.xfer_total;
          fill_count_nxt = '0;
          mode_nxt       = MODE_BUSY;
          ready_a_nxt    = 1'b0;
          ready_b_nxt    = 1'b0;
          fill_sel_nxt   = 1'b0;
          tx_active_nxt  = 1'b0;
          acc_f          = 1'b1;
        end
      end
      OP_WRITE: begin
        if (mode_r == MODE_BUSY && free_cur != '0) begin
          acc_f          = 1'b1;
          fill_count_nxt = fc_sum;
          if (fc_sum >= eff_size
              || {{(WORD_W-LEN_W){1'b0}}, fc_sum} >= bytes_left_r) begin
            if (!fill_sel_r) ready_a_nxt = 1'b1;
            else ready_b_nxt = 1'b1;
            fill_sel_nxt   = !fill_sel_r;
            fill_count_nxt = '0;
            if (!tx_active_r && !in_r.engine_busy) begin
              start_f       = 1'b1;
              tx_active_nxt = 1'b1;
              tx_sel_nxt    = !ra_now;
              if (ra_now) ready_a_nxt = 1'b0;
              else ready_b_nxt = 1'b0;
              tx_len_nxt = (bytes_left_r > eff_size_w) ? eff_size
                                                       : bytes_left_r[LEN_W-1:0];
            end
          end
        end
      end
      OP_DMA_EVENT: begin
        if (mode_r == MODE_BUSY) begin
          if (in_r.tc_flag) begin
            bytes_left_nxt = left_after;
            tx_active_nxt  = 1'b0;
            tx_len_nxt     = '0;
            if (left_after == '0) begin
              mode_nxt = MODE_COMPLETE;
              stop_f   = 1'b1;
              compl_f  = 1'b1;
            end else if (ready_a_r || ready_b_r) begin
              start_f       = 1'b1;
              tx_active_nxt = 1'b1;
              tx_sel_nxt    = !ready_a_r;
              if (ready_a_r) ready_a_nxt = 1'b0;
              else ready_b_nxt = 1'b0;
              tx_len_nxt = (left_after > eff_size_w) ? eff_size : left_after[LEN_W-1:0];
            end
          end
          if (in_r.err_flag) begin
            mode_nxt = MODE_ERROR;
            stop_f   = 1'b1;
            err_f    = 1'b1;
          end
        end
      end
      OP_STOP: begin
        stop_f         = 1'b1;
        mode_nxt       = MODE_READY;
        bytes_left_nxt = '0;
        tx_active_nxt  = 1'b0;
        ready_a_nxt    = 1'b0;
        ready_b_nxt    = 1'b0;
        fill_count_nxt = '0;
      end
      default: ;
    endcase
  end

  // result beat
  always_comb begin
    res_nxt                = '0;
    res_nxt.accepted       = acc_f;
    res_nxt.start_xfer     = start_f;
    res_nxt.stop_xfer      = stop_f;
    res_nxt.complete_event = compl_f;
    res_nxt.error_event    = err_f;
    if (acc_f && op_t'(in_r.op) == OP_WRITE) begin
      res_nxt.copy_bytes = copy_c;
      res_nxt.fill_addr  = fill_base + {{(WORD_W-LEN_W){1'b0}}, fill_count_r};
    end
    if (start_f) begin
      res_nxt.xfer_addr = tx_sel_nxt ? cfg.base_b : cfg.base_a;
      res_nxt.xfer_len  = tx_len_nxt;
    end
    res_nxt.run_state  = mode_nxt;
    res_nxt.remaining  = bytes_left_nxt;
    res_nxt.space_left = free_of(mode_nxt, tx_active_nxt, tx_sel_nxt, fill_sel_nxt,
                                 fill_count_nxt, eff_size);
  end

endmodule

`default_nettype wire

### tb/dma_ping_pong_buffer_controller_tb.sv
// self-checking testbench for the ping-pong dma transmit controller
// drives command beats and apb register writes, predicts every result beat
// depends on dppb_pkg and dma_ping_pong_buffer_controller
`timescale 1ns / 1ps

module dma_ping_pong_buffer_controller_tb;

  import dppb_pkg::*;

  localparam int unsigned MAX_BUF     = 65536;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP   = 100;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [WORD_W-1:0]   pwdata;
  logic [WORD_W-1:0]   prdata;
  logic                pready;

  int unsigned err_count;
  int unsigned cycle_cnt;
  int unsigned idle_pct;
  int unsigned stall_pct;

  out_t dma_status_q[$];

  // register shadow
  logic [31:0] sh_base_a;
  logic [31:0] sh_base_b;
  logic [16:0] sh_size;

  // controller state copy
  mode_t       m_mode;
  logic        m_fill_sel;
  logic [16:0] m_fill_cnt;
  logic [31:0] m_left;
  logic        m_rdy_a;
  logic        m_rdy_b;
  logic        m_tx_on;
  logic        m_tx_sel;
  logic [16:0] m_tx_len;

  dma_ping_pong_buffer_controller #(
    .MAX_BUFFER_BYTES(MAX_BUF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("dma_ping_pong_buffer_controller_tb: errors");
    $finish;
  end

  function automatic void reset_model();
    sh_base_a  = '0;
    sh_base_b  = '0;
    sh_size    = BUF_SIZE_RESET;
    m_mode     = MODE_READY;
    m_fill_sel = 1'b0;
    m_fill_cnt = '0;
    m_left     = '0;
    m_rdy_a    = 1'b0;
    m_rdy_b    = 1'b0;
    m_tx_on    = 1'b0;
    m_tx_sel   = 1'b0;
    m_tx_len   = '0;
  endfunction

  function automatic logic [16:0] eff_size();
    if (sh_size == 17'd0) return 17'd1;
    if (sh_size > MAX_BUF) return 17'(MAX_BUF);
    return sh_size;
  endfunction

  function automatic logic [31:0] buf_base(logic sel);
    return sel ? sh_base_b : sh_base_a;
  endfunction

  function automatic logic [16:0] free_bytes();
    logic [16:0] s;
    s = eff_size();
    if (m_mode != MODE_BUSY) return '0;
    if (m_tx_on && m_tx_sel == m_fill_sel) return '0;
    return (m_fill_cnt >= s) ? 17'd0 : s - m_fill_cnt;
  endfunction

  // send a ready buffer unless it is the one in flight
  function automatic void launch_ready(inout out_t r);
    logic        sel;
    logic [16:0] s;
    s = eff_size();
    if (m_rdy_a && !(m_tx_on && m_tx_sel == 1'b0)) begin
      sel = 1'b0;
      m_rdy_a = 1'b0;
    end else if (m_rdy_b && !(m_tx_on && m_tx_sel == 1'b1)) begin
      sel = 1'b1;
      m_rdy_b = 1'b0;
    end else begin
      return;
    end
    m_tx_on  = 1'b1;
    m_tx_sel = sel;
    m_tx_len = (m_left > {15'd0, s}) ? s : m_left[16:0];
    r.start_xfer = 1'b1;
    r.xfer_addr  = buf_base(sel);
    r.xfer_len   = m_tx_len;
  endfunction

  function automatic out_t dma_ctl_step(in_t b);
    out_t        r;
    logic [16:0] fs;
    logic [16:0] c;
    logic [31:0] done;
    r = '0;
    case (b.op)
      OP_START: begin
        if (m_mode != MODE_BUSY) begin
          m_left     = b.xfer_total;
          m_fill_cnt = '0;
          m_mode     = MODE_BUSY;
          m_rdy_a    = 1'b0;
          m_rdy_b    = 1'b0;
          m_fill_sel = 1'b0;
          m_tx_on    = 1'b0;
          r.accepted = 1'b1;
        end
      end
      OP_WRITE: begin
        fs = free_bytes();
        if (m_mode == MODE_BUSY && fs != 17'd0) begin
          c = (b.request_len > fs) ? fs : b.request_len;
          r.accepted   = 1'b1;
          r.copy_bytes = c;
          r.fill_addr  = buf_base(m_fill_sel) + {15'd0, m_fill_cnt};
          m_fill_cnt   = m_fill_cnt + c;
          if (m_fill_cnt >= eff_size() || {15'd0, m_fill_cnt} >= m_left) begin
            if (m_fill_sel) m_rdy_b = 1'b1;
            else m_rdy_a = 1'b1;
            m_fill_sel = ~m_fill_sel;
            m_fill_cnt = '0;
            if (!m_tx_on && !b.engine_busy) launch_ready(r);
          end
        end
      end
      OP_DMA_EVENT: begin
        if (m_mode == MODE_BUSY) begin
          if (b.tc_flag) begin
            done     = ({15'd0, m_tx_len} > m_left) ? m_left : {15'd0, m_tx_len};
            m_left   = m_left - done;
            m_tx_on  = 1'b0;
            m_tx_len = '0;
            if (m_left == 32'd0) begin
              m_mode           = MODE_COMPLETE;
              r.stop_xfer      = 1'b1;
              r.complete_event = 1'b1;
            end else begin
              launch_ready(r);
            end
          end
          if (b.err_flag) begin
            m_mode        = MODE_ERROR;
            r.stop_xfer   = 1'b1;
            r.error_event = 1'b1;
          end
        end
      end
      OP_STOP: begin
        r.stop_xfer = 1'b1;
        m_mode      = MODE_READY;
        m_left      = '0;
        m_tx_on     = 1'b0;
        m_rdy_a     = 1'b0;
        m_rdy_b     = 1'b0;
        m_fill_cnt  = '0;
      end
      default: begin
      end
    endcase
    r.run_state  = m_mode;
    r.remaining  = m_left;
    r.space_left = free_bytes();
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    err_count++;
    if (err_count <= PRINT_CAP) $display("mismatch %0d at %0t: %s", err_count, $realtime, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_beat(out_t got, out_t want);
    check_field("accepted", 32'(got.accepted), 32'(want.accepted));
    check_field("copy_bytes", 32'(got.copy_bytes), 32'(want.copy_bytes));
    check_field("fill_addr", got.fill_addr, want.fill_addr);
    check_field("start_xfer", 32'(got.start_xfer), 32'(want.start_xfer));
    check_field("xfer_addr", got.xfer_addr, want.xfer_addr);
    check_field("xfer_len", 32'(got.xfer_len), 32'(want.xfer_len));
    check_field("stop_xfer", 32'(got.stop_xfer), 32'(want.stop_xfer));
    check_field("complete_event", 32'(got.complete_event), 32'(want.complete_event));
    check_field("error_event", 32'(got.error_event), 32'(want.error_event));
    check_field("run_state", 32'(got.run_state), 32'(want.run_state));
    check_field("remaining", got.remaining, want.remaining);
    check_field("space_left", 32'(got.space_left), 32'(want.space_left));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (dma_status_q.size() == 0) flag_mismatch("result beat with nothing expected");
      else check_beat(out_data, dma_status_q.pop_front());
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  function automatic in_t cmd(logic [2:0] op, logic [31:0] total, logic [16:0] len,
                              logic busy, logic tc, logic err);
    in_t b;
    b.op          = op;
    b.xfer_total  = total;
    b.request_len = len;
    b.engine_busy = busy;
    b.tc_flag     = tc;
    b.err_flag    = err;
    return b;
  endfunction

  task automatic send_cmd(in_t b);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    dma_status_q.push_back(dma_ctl_step(b));
  endtask

  // park the input side and let every result beat come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (dma_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    case (idx)
      REG_BASE_A:   sh_base_a = val;
      REG_BASE_B:   sh_base_b = val;
      REG_BUF_SIZE: sh_size   = val[16:0];
      default: begin
      end
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic test_idle_commands();
    send_cmd(cmd(OP_STATUS, 32'd0, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd100, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_DMA_EVENT, 32'd0, 17'd0, 1'b1, 1'b1, 1'b1));
    send_cmd(cmd(3'd7, 32'hFFFF_FFFF, 17'h1FFFF, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_buffer_flow();
    settle();
    apb_write(REG_BASE_A, 32'hFFFF_FFF8);
    apb_write(REG_BASE_B, 32'h0000_1000);
    apb_write(REG_BUF_SIZE, 32'd16);
    send_cmd(cmd(OP_START, 32'd40, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_START, 32'd5, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd10, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd65536, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd16, 1'b1, 1'b0, 1'b0));
    send_cmd(cmd(OP_DMA_EVENT, 32'd0, 17'd0, 1'b0, 1'b1, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd8, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_DMA_EVENT, 32'd0, 17'd0, 1'b0, 1'b1, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_DMA_EVENT, 32'd0, 17'd0, 1'b0, 1'b1, 1'b1));
    // error while in flight leaves the length held across a restart
    send_cmd(cmd(OP_START, 32'd100, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd16, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_DMA_EVENT, 32'd0, 17'd0, 1'b0, 1'b0, 1'b1));
    send_cmd(cmd(OP_START, 32'd20, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_DMA_EVENT, 32'd0, 17'd0, 1'b0, 1'b1, 1'b0));
    send_cmd(cmd(OP_STOP, 32'd0, 17'd0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_size_limits();
    settle();
    apb_write(REG_BUF_SIZE, 32'd64);
    send_cmd(cmd(OP_START, 32'd1000, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd40, 1'b0, 1'b0, 1'b0));
    settle();
    // shrink below the fill count
    apb_write(REG_BUF_SIZE, 32'd8);
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd5, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_STOP, 32'd0, 17'd0, 1'b0, 1'b0, 1'b0));
    settle();
    apb_write(REG_BUF_SIZE, 32'd0);
    send_cmd(cmd(OP_START, 32'd3, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd5, 1'b0, 1'b0, 1'b0));
    settle();
    apb_write(REG_BUF_SIZE, 32'h0001_FFFF);
    send_cmd(cmd(OP_START, 32'hFFFF_FFFF, 17'd0, 1'b0, 1'b0, 1'b0));
    send_cmd(cmd(OP_WRITE, 32'd0, 17'd65536, 1'b0, 1'b0, 1'b0));
  endtask

  function automatic in_t pick_cmd();
    in_t         b;
    int unsigned r;
    int unsigned s;
    int unsigned top;
    b.op          = OP_STATUS;
    b.xfer_total  = $urandom;
    b.request_len = 17'($urandom_range(0, 65536));
    b.engine_busy = ($urandom_range(3) == 0);
    b.tc_flag     = 1'($urandom_range(1));
    b.err_flag    = 1'($urandom_range(1));
    s   = eff_size();
    top = (s + s / 4 > 65536) ? 65536 : s + s / 4;
    r   = $urandom_range(99);
    if (m_mode != MODE_BUSY && r < 75) begin
      b.op = OP_START;
    end else if (m_mode != MODE_BUSY || r >= 93) begin
      b.op = 3'($urandom_range(7));
    end else if (r < 50) begin
      b.op = OP_WRITE;
    end else if (r < 78) begin
      b.op       = OP_DMA_EVENT;
      b.tc_flag  = 1'b1;
      b.err_flag = ($urandom_range(39) == 0);
    end else if (r < 82) begin
      b.op = OP_DMA_EVENT;
    end else if (r < 85) begin
      b.op = OP_STOP;
    end else if (r < 89) begin
      b.op = OP_STATUS;
    end else begin
      b.op = OP_START;
    end
    if (b.op == OP_START && $urandom_range(9) != 0) b.xfer_total = $urandom_range(0, 4 * s);
    if (b.op == OP_WRITE && $urandom_range(6) != 0) b.request_len = 17'($urandom_range(0, top));
    return b;
  endfunction

  function automatic logic [31:0] size_for(int unsigned idx);
    case (idx)
      0: return 32'd16;
      1: return 32'd1;
      2: return 32'd0;
      3: return 32'd7;
      4: return 32'd65536;
      5: return 32'd100;
      6: return 32'h0001_FFFF;
      default: return 32'd3;
    endcase
  endfunction

  task automatic test_random_traffic();
    int unsigned idx;
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 2; k++) begin
        settle();
        idx       = ph * 2 + k;
        idle_pct  = (ph == 1) ? 80 : (ph == 3) ? 21 : 0;
        stall_pct = (ph == 2) ? 80 : (ph == 3) ? 21 : 0;
        apb_write(REG_BASE_A, (idx == 0) ? 32'd0 : $urandom);
        apb_write(REG_BASE_B, (idx == 0) ? 32'hFFFF_FFFF : $urandom);
        apb_write(REG_BUF_SIZE, size_for(idx));
        for (int n = 0; n < 88; n++) send_cmd(pick_cmd());
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    err_count = 0;
    idle_pct  = 0;
    stall_pct = 0;
    reset_model();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_idle_commands();
    test_buffer_flow();
    test_size_limits();
    test_random_traffic();
    settle();
    if (err_count == 0) $display("dma_ping_pong_buffer_controller_tb: clean");
    else $display("dma_ping_pong_buffer_controller_tb: errors");
    $finish;
  end

endmodule
